@@ design/pixel_buffer_access_unit_assert.svh @@
// Assertion macros for the pixel buffer access unit.
// Simulation builds get concurrent assertions; synthesis builds define SYNTH
// and every macro expands to nothing.
`ifndef PIXEL_BUFFER_ACCESS_UNIT_ASSERT_SVH
`define PIXEL_BUFFER_ACCESS_UNIT_ASSERT_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define PBAU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pixel buffer assertion failed");
// A condition that must never be seen outside reset.
`define PBAU_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pixel buffer forbidden condition seen");
`else
`define PBAU_ASSERT(name, clk, rst, prop)
`define PBAU_NEVER(name, clk, rst, cond)
`endif
`endif

@@ design/pbau_pkg.sv @@
`default_nettype none

package pbau_pkg;

   // Field widths of the request, response and register port.
   localparam int POS_W       = 14;
   localparam int COMP_W      = 8;
   localparam int RAW_W       = 32;
   localparam int CFG_DIM_W   = 15;
   localparam int FMT_W       = 3;
   localparam int PITCH_CFG_W = 17;
   localparam int REQ_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 17;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 72;

   // Default sizes.
   localparam int DEF_MEM_BYTES = 65536;
   localparam int DEF_MAX_DIM   = 16384;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_COLOR_WRITE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_COLOR_READ  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_RAW_WRITE   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RAW_READ    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR_DIRTY = 3'd4;

   // Pixel format codes.
   localparam logic [FMT_W-1:0] FMT_NONE   = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGB332 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGB888 = 3'd3;
   localparam logic [FMT_W-1:0] FMT_ARGB   = 3'd4;
   localparam logic [FMT_W-1:0] FMT_XRGB   = 3'd5;
   localparam logic [FMT_W-1:0] FMT_BGRA   = 3'd6;
   localparam logic [FMT_W-1:0] FMT_BGR565 = 3'd7;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_FORMAT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_PITCH   = 2'd3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SUM,
      ST_ACCESS,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic sum;
      logic access;
      logic clr_en;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic skip;
      logic beyond;
      logic last_byte;
      logic is_read;
   } sts_type;

   // Bytes per pixel; unknown formats use four bytes.
   function automatic logic [2:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
      logic [2:0] bpp;
      unique case (fmt)
         FMT_RGB332:             bpp = 3'd1;
         FMT_RGB565, FMT_BGR565: bpp = 3'd2;
         FMT_RGB888:             bpp = 3'd3;
         default:                bpp = 3'd4;
      endcase
      return bpp;
   endfunction

   // Widen a 2-bit field to eight bits: v * 255 / 3 is v * 85.
   function automatic logic [7:0] widen2(input logic [1:0] v);
      return {v, v, v, v};
   endfunction

   // Widen a 3-bit field: v * 255 / 7 is 36 * v plus floor(3 * v / 7).
   function automatic logic [7:0] widen3(input logic [2:0] v);
      return {v, 5'b0} + {3'b0, v, 2'b0} + 8'(v >= 3'd3) + 8'(v >= 3'd5)
             + 8'(v >= 3'd7);
   endfunction

   // Widen a 5-bit field: v * 255 / 31 is 8 * v plus floor(7 * v / 31).
   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, 3'b0} + 8'(v >= 5'd5) + 8'(v >= 5'd9) + 8'(v >= 5'd14)
             + 8'(v >= 5'd18) + 8'(v >= 5'd23) + 8'(v >= 5'd27) + 8'(v >= 5'd31);
   endfunction

   // Widen a 6-bit field: v * 255 / 63 is 4 * v plus floor(v / 21).
   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, 2'b0} + 8'(v >= 6'd21) + 8'(v >= 6'd42) + 8'(v >= 6'd63);
   endfunction

endpackage

`default_nettype wire

@@ design/pbau_ram.sv @@
`default_nettype none

module pbau_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port, read before write (a write cycle returns the old contents), read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/pbau_ctrl.sv @@
`default_nettype none

module pbau_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire pbau_pkg::sts_type sts,
   output pbau_pkg::cmd_type      cmd
);

   pbau_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbau_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = pbau_pkg::ST_IDLE;
         end
         pbau_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = pbau_pkg::ST_PREP;
         end
         pbau_pkg::ST_PREP: begin
            state_in = pbau_pkg::ST_MUL;
         end
         pbau_pkg::ST_MUL: begin
            state_in = sts.skip ? pbau_pkg::ST_DONE : pbau_pkg::ST_SUM;
         end
         pbau_pkg::ST_SUM: begin
            state_in = pbau_pkg::ST_ACCESS;
         end
         pbau_pkg::ST_ACCESS: begin
            priority if (sts.beyond) begin
               state_in = pbau_pkg::ST_DONE;
            end else if (sts.last_byte) begin
               state_in = sts.is_read ? pbau_pkg::ST_DRAIN : pbau_pkg::ST_DONE;
            end else begin
               state_in = pbau_pkg::ST_ACCESS;
            end
         end
         pbau_pkg::ST_DRAIN: begin
            state_in = pbau_pkg::ST_DONE;
         end
         pbau_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = pbau_pkg::ST_IDLE;
         end
         default: begin
            state_in = pbau_pkg::ST_CLEAR;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pbau_pkg::ST_CLEAR:  cmd.clr_en = 1'b1;
         pbau_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         pbau_pkg::ST_PREP:   cmd.prep = 1'b1;
         pbau_pkg::ST_MUL:    cmd.mul = 1'b1;
         pbau_pkg::ST_SUM:    cmd.sum = 1'b1;
         pbau_pkg::ST_ACCESS: cmd.access = !sts.beyond;
         pbau_pkg::ST_DRAIN:  cmd = '0;
         pbau_pkg::ST_DONE:   cmd.finish = !rsp_valid_ff || rsp_tready;
         default:             cmd = '0;
      endcase
   end

   // The response register is full from a finish until it is taken.
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbau_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ design/pbau_datapath.sv @@
`default_nettype none

module pbau_datapath #(
   parameter int MEM_BYTES = pbau_pkg::DEF_MEM_BYTES,
   parameter int MAX_DIM   = pbau_pkg::DEF_MAX_DIM
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pbau_pkg::cmd_type                   cmd,
   output pbau_pkg::sts_type                        sts,
   input  wire logic [pbau_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [pbau_pkg::REQ_W-1:0]          req_tuser,
   input  wire logic                                csr_we,
   input  wire logic [pbau_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [pbau_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic      [$clog2(MEM_BYTES)-1:0]        mem_addr,
   output logic                                     mem_we,
   output logic      [7:0]                          mem_wdata,
   input  wire logic [7:0]                          mem_rdata,
   output logic      [pbau_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic      [pbau_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int ADDR_W  = $clog2(MEM_BYTES);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int WB_W    = DIM_W + 2;
   localparam int PITCH_W = (WB_W > pbau_pkg::PITCH_CFG_W) ? WB_W : pbau_pkg::PITCH_CFG_W;
   localparam int XB_W    = pbau_pkg::POS_W + 2;
   localparam int PROD_W  = pbau_pkg::POS_W + PITCH_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int RAW_W   = pbau_pkg::RAW_W;
   localparam int COMP_W  = pbau_pkg::COMP_W;

   // Configuration registers.
   logic [pbau_pkg::CFG_DIM_W-1:0]   width_ff, height_ff;
   logic [pbau_pkg::FMT_W-1:0]       fmt_ff;
   logic [pbau_pkg::PITCH_CFG_W-1:0] pitch_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= pbau_pkg::CFG_DIM_W'(1);
         height_ff    <= pbau_pkg::CFG_DIM_W'(1);
         fmt_ff       <= pbau_pkg::FMT_XRGB;
         pitch_cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            pbau_pkg::CSR_FRAME_WIDTH:  width_ff     <= csr_wdata[pbau_pkg::CFG_DIM_W-1:0];
            pbau_pkg::CSR_FRAME_HEIGHT: height_ff    <= csr_wdata[pbau_pkg::CFG_DIM_W-1:0];
            pbau_pkg::CSR_PIXEL_FORMAT: fmt_ff       <= csr_wdata[pbau_pkg::FMT_W-1:0];
            pbau_pkg::CSR_LINE_PITCH:   pitch_cfg_ff <= csr_wdata;
            default:                    fmt_ff       <= fmt_ff;
         endcase
      end
   end

   // Request registers, loaded when the request is accepted.
   logic [pbau_pkg::REQ_W-1:0] req_ff;
   logic [pbau_pkg::POS_W-1:0] x_ff, y_ff;
   logic [COMP_W-1:0]          red_ff, green_ff, blue_ff, alpha_ff;
   logic [RAW_W-1:0]           raw_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_tuser;
         x_ff     <= req_tdata[13:0];
         y_ff     <= req_tdata[27:14];
         red_ff   <= req_tdata[35:28];
         green_ff <= req_tdata[43:36];
         blue_ff  <= req_tdata[51:44];
         alpha_ff <= req_tdata[59:52];
         raw_ff   <= req_tdata[91:60];
      end
   end

   // Request classification.
   logic is_read, is_write, access_op, store_ok;

   assign is_read   = (req_ff == pbau_pkg::REQ_COLOR_READ) || (req_ff == pbau_pkg::REQ_RAW_READ);
   assign is_write  = (req_ff == pbau_pkg::REQ_COLOR_WRITE) ||
                      (req_ff == pbau_pkg::REQ_RAW_WRITE);
   assign access_op = is_read || is_write;
   // A colour write with no valid format stores nothing.
   assign store_ok  = !((req_ff == pbau_pkg::REQ_COLOR_WRITE) && (fmt_ff == pbau_pkg::FMT_NONE));

   // Clamped frame size and pixel size.
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [2:0]       bpp;
   logic [1:0]       bpp_m1;

   assign w_eff  = (32'(width_ff) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(width_ff);
   assign h_eff  = (32'(height_ff) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(height_ff);
   assign bpp    = pbau_pkg::bytes_per_pixel(fmt_ff);
   assign bpp_m1 = 2'(bpp - 3'd1);

   // Row pitch and column byte offset by shift and add.
   logic [WB_W-1:0]    wb, wb_round;
   logic [XB_W-1:0]    xb_in;
   logic [PITCH_W-1:0] pitch_in;
   logic               oor;

   always_comb begin
      unique case (bpp)
         3'd1: begin
            wb    = WB_W'(w_eff);
            xb_in = XB_W'(x_ff);
         end
         3'd2: begin
            wb    = WB_W'({w_eff, 1'b0});
            xb_in = XB_W'({x_ff, 1'b0});
         end
         3'd3: begin
            wb    = WB_W'(w_eff) + WB_W'({w_eff, 1'b0});
            xb_in = XB_W'(x_ff) + XB_W'({x_ff, 1'b0});
         end
         default: begin
            wb    = WB_W'({w_eff, 2'b0});
            xb_in = XB_W'({x_ff, 2'b0});
         end
      endcase
   end

   assign wb_round = (wb + WB_W'(3)) & ~WB_W'(3);
   assign pitch_in = (pitch_cfg_ff != '0) ? PITCH_W'(pitch_cfg_ff) : PITCH_W'(wb_round);
   assign oor      = (32'(x_ff) >= 32'(w_eff)) || (32'(y_ff) >= 32'(h_eff));

   // Address calculation registers.
   logic [PITCH_W-1:0] pitch_ff;
   logic [XB_W-1:0]    xb_ff;
   logic               oor_ff, skip_ff, beyond_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [ADDR_W-1:0]  ofs_ff;
   logic [SUM_W-1:0]   ofs_full, ofs_end;

   assign ofs_full = SUM_W'(prod_ff) + SUM_W'(xb_ff);
   assign ofs_end  = ofs_full + SUM_W'(bpp);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         pitch_ff <= pitch_in;
         xb_ff    <= xb_in;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(y_ff) * PROD_W'(pitch_ff);
      end
      if (cmd.sum) begin
         ofs_ff <= ofs_full[ADDR_W-1:0];
      end
   end

   // Flags that steer the controller.
   always_ff @(posedge clock) begin
      if (reset) begin
         oor_ff    <= 1'b0;
         skip_ff   <= 1'b0;
         beyond_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            beyond_ff <= 1'b0;
         end else if (cmd.sum) begin
            beyond_ff <= ofs_end > SUM_W'(MEM_BYTES);
         end
         if (cmd.prep) begin
            oor_ff  <= access_op && oor;
            skip_ff <= !access_op || oor;
         end
      end
   end

   // Packed pixel word to store.
   logic [RAW_W-1:0] wr_word;

   always_comb begin
      if (req_ff == pbau_pkg::REQ_RAW_WRITE) begin
         wr_word = raw_ff;
      end else begin
         unique case (fmt_ff)
            pbau_pkg::FMT_RGB332:
               wr_word = {24'd0, red_ff[7:5], green_ff[7:5], blue_ff[7:6]};
            pbau_pkg::FMT_RGB565:
               wr_word = {16'd0, red_ff[7:3], green_ff[7:2], blue_ff[7:3]};
            pbau_pkg::FMT_BGR565:
               wr_word = {16'd0, blue_ff[7:3], green_ff[7:2], red_ff[7:3]};
            pbau_pkg::FMT_RGB888:
               wr_word = {8'd0, blue_ff, green_ff, red_ff};
            pbau_pkg::FMT_ARGB, pbau_pkg::FMT_XRGB, pbau_pkg::FMT_BGRA:
               wr_word = {alpha_ff, red_ff, green_ff, blue_ff};
            default:
               wr_word = '0;
         endcase
      end
   end

   // Byte counter and clearing sweep.
   logic [1:0]        cnt_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.access) begin
            cnt_ff <= cnt_ff + 2'd1;
         end
         if (cmd.clr_en) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   // Memory port: the clearing sweep writes zeros, an access moves one byte a cycle.
   assign mem_addr  = cmd.clr_en ? clr_addr_ff : ofs_ff + ADDR_W'(cnt_ff);
   assign mem_we    = cmd.clr_en || (cmd.access && is_write && store_ok);
   assign mem_wdata = cmd.clr_en ? 8'd0 : wr_word[8*cnt_ff +: 8];

   // Read bytes arrive in the cycle after their address and are placed by index.
   logic             cap_vld_ff;
   logic [1:0]       cap_idx_ff;
   logic [RAW_W-1:0] word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_vld_ff <= 1'b0;
      end else begin
         cap_vld_ff <= cmd.access && is_read;
      end
      cap_idx_ff <= cnt_ff;
      if (cmd.load) begin
         word_ff <= '0;
      end else if (cap_vld_ff) begin
         word_ff[8*cap_idx_ff +: 8] <= mem_rdata;
      end
   end

   // Result assembly.
   logic [pbau_pkg::STATUS_W-1:0] status_val;
   logic [COMP_W-1:0]             o_red, o_green, o_blue, o_alpha;
   logic [RAW_W-1:0]              o_raw;
   logic                          dirty_ff, dirty_in;

   always_comb begin
      priority if (oor_ff) begin
         status_val = pbau_pkg::STATUS_RANGE;
      end else if (beyond_ff) begin
         status_val = pbau_pkg::STATUS_BEYOND;
      end else begin
         status_val = pbau_pkg::STATUS_OK;
      end
   end

   always_comb begin
      o_red   = '0;
      o_green = '0;
      o_blue  = '0;
      o_alpha = '0;
      o_raw   = '0;
      if (status_val == pbau_pkg::STATUS_OK && req_ff == pbau_pkg::REQ_RAW_READ) begin
         o_raw = word_ff;
      end
      if (status_val == pbau_pkg::STATUS_OK && req_ff == pbau_pkg::REQ_COLOR_READ) begin
         unique case (fmt_ff)
            pbau_pkg::FMT_RGB332: begin
               o_red   = pbau_pkg::widen3(word_ff[7:5]);
               o_green = pbau_pkg::widen3(word_ff[4:2]);
               o_blue  = pbau_pkg::widen2(word_ff[1:0]);
               o_alpha = 8'hFF;
            end
            pbau_pkg::FMT_RGB565: begin
               o_red   = pbau_pkg::widen5(word_ff[15:11]);
               o_green = pbau_pkg::widen6(word_ff[10:5]);
               o_blue  = pbau_pkg::widen5(word_ff[4:0]);
               o_alpha = 8'hFF;
            end
            pbau_pkg::FMT_BGR565: begin
               o_blue  = pbau_pkg::widen5(word_ff[15:11]);
               o_green = pbau_pkg::widen6(word_ff[10:5]);
               o_red   = pbau_pkg::widen5(word_ff[4:0]);
               o_alpha = 8'hFF;
            end
            pbau_pkg::FMT_RGB888: begin
               o_red   = word_ff[7:0];
               o_green = word_ff[15:8];
               o_blue  = word_ff[23:16];
               o_alpha = 8'hFF;
            end
            pbau_pkg::FMT_ARGB, pbau_pkg::FMT_XRGB, pbau_pkg::FMT_BGRA: begin
               o_blue  = word_ff[7:0];
               o_green = word_ff[15:8];
               o_red   = word_ff[23:16];
               o_alpha = word_ff[31:24];
            end
            default: begin
               o_alpha = '0;
            end
         endcase
      end
   end

   // The dirty mark is cleared on request and set by every successful write.
   always_comb begin
      priority if (req_ff == pbau_pkg::REQ_CLEAR_DIRTY) begin
         dirty_in = 1'b0;
      end else if (is_write && status_val == pbau_pkg::STATUS_OK) begin
         dirty_in = 1'b1;
      end else begin
         dirty_in = dirty_ff;
      end
   end

   // Response register and dirty mark.
   logic [pbau_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [pbau_pkg::STATUS_W-1:0]    rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
      end else if (cmd.finish) begin
         dirty_ff <= dirty_in;
      end
      if (cmd.finish) begin
         rsp_tdata_ff <= {7'd0, dirty_in, o_raw, o_alpha, o_blue, o_green, o_red};
         rsp_tuser_ff <= status_val;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // Status toward the controller.
   assign sts.clr_last  = clr_addr_ff == ADDR_W'(MEM_BYTES - 1);
   assign sts.skip      = skip_ff;
   assign sts.beyond    = beyond_ff;
   assign sts.last_byte = cnt_ff == bpp_m1;
   assign sts.is_read   = is_read;

endmodule

`default_nettype wire

@@ design/pixel_buffer_access_unit.sv @@
// Pixel buffer access unit: a byte-wide frame memory of MEM_BYTES bytes with one request
// channel and one response channel. Each request is a colour write, colour read, raw
// write, raw read or a clear of the dirty mark; each gives exactly one response with a
// status (ok, coordinate out of range, beyond memory), the read-back colour or raw word
// and the dirty mark. After reset the memory is swept to zero one byte per cycle; no
// request is taken during the sweep, while register writes are. One request is worked
// on at a time. A clear of the dirty mark, an unknown code or an out-of-range coordinate
// goes from the row multiply straight to the response; an access beyond memory moves no
// byte; a read has a drain state after its last byte. The single byte-wide port of the
// pixel memory moves one byte per cycle, after the operand setup, row multiply and offset
// add steps. A finished response waits in an output register while the next request is
// accepted. Registers should be written only while the block idles.
`default_nettype none

module pixel_buffer_access_unit #(
   parameter int MEM_BYTES = pbau_pkg::DEF_MEM_BYTES,
   parameter int MAX_DIM   = pbau_pkg::DEF_MAX_DIM
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // pos_x[13:0], pos_y[27:14], in_red[35:28], in_green[43:36], in_blue[51:44],
   // in_alpha[59:52], in_raw[91:60], zero pad [95:92]
   input  wire logic [pbau_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[2:0]
   input  wire logic [pbau_pkg::REQ_W-1:0]       req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
   // out_raw[63:32], dirty[64], zero pad [71:65]
   output logic      [pbau_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic      [pbau_pkg::STATUS_W-1:0]    rsp_tuser,
   // Register write port.
   input  wire logic                             csr_we,
   input  wire logic [pbau_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [pbau_pkg::CSR_DATA_W-1:0]  csr_wdata
);

`include "pixel_buffer_access_unit_assert.svh"

   localparam int ADDR_W = $clog2(MEM_BYTES);

   pbau_pkg::cmd_type cmd;
   pbau_pkg::sts_type sts;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [7:0]        mem_wdata, mem_rdata;

   // Sequencer.
   pbau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Address arithmetic, pixel packing and response register.
   pbau_datapath #(
      .MEM_BYTES (MEM_BYTES),
      .MAX_DIM   (MAX_DIM)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .mem_addr  (mem_addr),
      .mem_we    (mem_we),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Pixel memory.
   pbau_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_pixel_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // The memory is never written while a new request can be taken.
   `PBAU_NEVER(a_no_write_when_ready, clock, reset, req_tready && mem_we)
   // Only one request is in work: an accepted request closes the input next cycle.
   `PBAU_ASSERT(a_one_in_work, clock, reset, req_tvalid && req_tready |=> !req_tready)
   // The clearing sweep writes a zero byte every cycle.
   `PBAU_ASSERT(a_clear_writes_zero, clock, reset, cmd.clr_en |-> mem_we && mem_wdata == 8'd0)

endmodule

`default_nettype wire
